### hw/rtl/tfn_pkg.sv
// Shared widths, constants and stage payload types for the triangle face normal pipeline.
package tfn_pkg;

   localparam int COORD_FRAC_BITS = 16;

   localparam int CW   = 24;                 // vertex coordinate
   localparam int EW   = CW + 1;             // edge vector component
   localparam int PW   = 2 * EW;             // edge product
   localparam int NW   = PW + 1;             // cross product component
   localparam int AW   = NW - 1;             // cross product magnitude
   localparam int HW   = AW / 2;             // half of a magnitude for partial products
   localparam int SW   = 2 * AW + 2;         // sum of squares
   localparam int MW   = 40;                 // reduced magnitude
   localparam int MHW  = MW / 2;
   localparam int SRW  = 2 * MW + 2;         // sum of reduced squares
   localparam int BLW  = $clog2(AW + 1);     // bit length of a magnitude
   localparam int SHW  = $clog2(AW - MW + 1);
   localparam int QW   = 15;                 // unit component magnitude, 0..16384
   localparam int NSTEP = QW;                // digit steps of the normalization
   localparam int QSH  = 2 * QW;             // scale of the target, (2 * 2^14)^2
   localparam int RW   = 118;                // residual of the digit recurrence
   localparam int PPW  = 100;                // running product S' * (x - 1)
   localparam int OW   = 16;                 // Q1.14 output component
   localparam int LW   = 32;                 // threshold register
   localparam int TW   = 2 * LW;             // squared threshold

   localparam int SHIFT_D = 64 - 4 * COORD_FRAC_BITS;
   localparam int SHL  = (SHIFT_D > 0) ? SHIFT_D : 0;
   localparam int SHR  = (SHIFT_D < 0) ? -SHIFT_D : 0;
   localparam int CMPW = SW + 34;

   localparam logic [LW-1:0] MIN_LENGTH_RESET = 32'd4295;

   typedef struct packed {
      logic [2:0][AW-1:0] mag;
      logic [2:0]         neg;
   } cross_type;

   typedef struct packed {
      logic               degenerate;
      logic [2:0]         neg;
      logic [SRW-1:0]     s_red;
      logic [2:0][2*MW-1:0] msq;
   } unit_type;

endpackage

### hw/rtl/tfn_cross.sv
// Edge vectors, edge products and cross product magnitude/sign (three stages).
module tfn_cross (
   input  logic                            clock,
   input  logic [2:0]                      en,
   input  logic signed [tfn_pkg::CW-1:0]   vertex_a_x,
   input  logic signed [tfn_pkg::CW-1:0]   vertex_a_y,
   input  logic signed [tfn_pkg::CW-1:0]   vertex_a_z,
   input  logic signed [tfn_pkg::CW-1:0]   vertex_b_x,
   input  logic signed [tfn_pkg::CW-1:0]   vertex_b_y,
   input  logic signed [tfn_pkg::CW-1:0]   vertex_b_z,
   input  logic signed [tfn_pkg::CW-1:0]   vertex_c_x,
   input  logic signed [tfn_pkg::CW-1:0]   vertex_c_y,
   input  logic signed [tfn_pkg::CW-1:0]   vertex_c_z,
   output tfn_pkg::cross_type              cross_o
);

   logic signed [tfn_pkg::EW-1:0] e1_ff [3];
   logic signed [tfn_pkg::EW-1:0] e2_ff [3];
   logic signed [tfn_pkg::EW-1:0] e1_in [3];
   logic signed [tfn_pkg::EW-1:0] e2_in [3];
   logic signed [tfn_pkg::PW-1:0] prod_ff [6];
   logic signed [tfn_pkg::PW-1:0] prod_in [6];
   tfn_pkg::cross_type            cross_ff;
   tfn_pkg::cross_type            cross_in;
   logic signed [tfn_pkg::NW-1:0] n_w [3];

   always_comb begin
      e1_in[0] = {vertex_b_x[tfn_pkg::CW-1], vertex_b_x} - {vertex_a_x[tfn_pkg::CW-1], vertex_a_x};
      e1_in[1] = {vertex_b_y[tfn_pkg::CW-1], vertex_b_y} - {vertex_a_y[tfn_pkg::CW-1], vertex_a_y};
      e1_in[2] = {vertex_b_z[tfn_pkg::CW-1], vertex_b_z} - {vertex_a_z[tfn_pkg::CW-1], vertex_a_z};
      e2_in[0] = {vertex_c_x[tfn_pkg::CW-1], vertex_c_x} - {vertex_a_x[tfn_pkg::CW-1], vertex_a_x};
      e2_in[1] = {vertex_c_y[tfn_pkg::CW-1], vertex_c_y} - {vertex_a_y[tfn_pkg::CW-1], vertex_a_y};
      e2_in[2] = {vertex_c_z[tfn_pkg::CW-1], vertex_c_z} - {vertex_a_z[tfn_pkg::CW-1], vertex_a_z};
   end

   always_comb begin
      prod_in[0] = e1_ff[1] * e2_ff[2];
      prod_in[1] = e1_ff[2] * e2_ff[1];
      prod_in[2] = e1_ff[2] * e2_ff[0];
      prod_in[3] = e1_ff[0] * e2_ff[2];
      prod_in[4] = e1_ff[0] * e2_ff[1];
      prod_in[5] = e1_ff[1] * e2_ff[0];
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         n_w[c] = {prod_ff[2*c][tfn_pkg::PW-1], prod_ff[2*c]}
                - {prod_ff[2*c+1][tfn_pkg::PW-1], prod_ff[2*c+1]};
         cross_in.neg[c] = n_w[c][tfn_pkg::NW-1];
         cross_in.mag[c] = n_w[c][tfn_pkg::NW-1] ? tfn_pkg::AW'(-n_w[c])
                                                  : tfn_pkg::AW'(n_w[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
      end
      if (en[1]) begin
         prod_ff <= prod_in;
      end
      if (en[2]) begin
         cross_ff <= cross_in;
      end
   end

   assign cross_o = cross_ff;

endmodule

### hw/rtl/tfn_length.sv
// Squared length, threshold test and range reduction of the cross product (six stages).
module tfn_length (
   input  logic                      clock,
   input  logic [5:0]                en,
   input  tfn_pkg::cross_type        cross_i,
   input  logic [tfn_pkg::TW-1:0]    thr,
   output tfn_pkg::unit_type         unit_o
);

   // stage 4: partial squares and max
   logic [tfn_pkg::PW-1:0]   hh_ff [3], hl_ff [3], ll_ff [3];
   logic [tfn_pkg::PW-1:0]   hh_in [3], hl_in [3], ll_in [3];
   logic [tfn_pkg::AW-1:0]   a4_ff [3];
   logic [2:0]               neg4_ff;
   logic [tfn_pkg::AW-1:0]   mx_ff, mx_in;
   // stage 5: squares and shift
   logic [tfn_pkg::SW-1:0]   sq_ff [3], sq_in [3];
   logic [tfn_pkg::AW-1:0]   a5_ff [3];
   logic [2:0]               neg5_ff;
   logic [tfn_pkg::SHW-1:0]  sh_ff, sh_in;
   logic [tfn_pkg::BLW-1:0]  bl_w;
   // stage 6: sum and reduced magnitudes
   logic [tfn_pkg::SW-1:0]   s_ff, s_in;
   logic [tfn_pkg::MW-1:0]   m6_ff [3], m6_in [3];
   logic [2:0]               neg6_ff;
   // stage 7: threshold and reduced partial squares
   logic                     above_ff, above_in;
   logic [tfn_pkg::MW-1:0]   mhh_ff [3], mhl_ff [3], mll_ff [3];
   logic [tfn_pkg::MW-1:0]   mhh_in [3], mhl_in [3], mll_in [3];
   logic [2:0]               neg7_ff;
   // stage 8: reduced squares
   logic [2*tfn_pkg::MW-1:0] msq_ff [3], msq_in [3];
   logic                     degen8_ff;
   logic [2:0]               neg8_ff;
   // stage 9: reduced sum
   tfn_pkg::unit_type        unit_ff, unit_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         hh_in[c] = cross_i.mag[c][tfn_pkg::AW-1:tfn_pkg::HW] * cross_i.mag[c][tfn_pkg::AW-1:tfn_pkg::HW];
         hl_in[c] = cross_i.mag[c][tfn_pkg::AW-1:tfn_pkg::HW] * cross_i.mag[c][tfn_pkg::HW-1:0];
         ll_in[c] = cross_i.mag[c][tfn_pkg::HW-1:0] * cross_i.mag[c][tfn_pkg::HW-1:0];
      end
      mx_in = cross_i.mag[0];
      if (cross_i.mag[1] > mx_in) mx_in = cross_i.mag[1];
      if (cross_i.mag[2] > mx_in) mx_in = cross_i.mag[2];
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sq_in[c] = (tfn_pkg::SW'(hh_ff[c]) << (2 * tfn_pkg::HW))
                  + (tfn_pkg::SW'(hl_ff[c]) << (tfn_pkg::HW + 1))
                  + tfn_pkg::SW'(ll_ff[c]);
      end
      bl_w = '0;
      for (int i = 0; i < tfn_pkg::AW; i++) begin
         if (mx_ff[i]) bl_w = tfn_pkg::BLW'(i + 1);
      end
      sh_in = (bl_w > tfn_pkg::BLW'(tfn_pkg::MW)) ?
              tfn_pkg::SHW'(bl_w - tfn_pkg::BLW'(tfn_pkg::MW)) : '0;
   end

   always_comb begin
      s_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
      for (int c = 0; c < 3; c++) begin
         m6_in[c] = tfn_pkg::MW'(a5_ff[c] >> sh_ff);
      end
   end

   always_comb begin
      above_in = (tfn_pkg::CMPW'(s_ff) << tfn_pkg::SHL) > (tfn_pkg::CMPW'(thr) << tfn_pkg::SHR);
      for (int c = 0; c < 3; c++) begin
         mhh_in[c] = m6_ff[c][tfn_pkg::MW-1:tfn_pkg::MHW] * m6_ff[c][tfn_pkg::MW-1:tfn_pkg::MHW];
         mhl_in[c] = m6_ff[c][tfn_pkg::MW-1:tfn_pkg::MHW] * m6_ff[c][tfn_pkg::MHW-1:0];
         mll_in[c] = m6_ff[c][tfn_pkg::MHW-1:0] * m6_ff[c][tfn_pkg::MHW-1:0];
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         msq_in[c] = ((2*tfn_pkg::MW)'(mhh_ff[c]) << (2 * tfn_pkg::MHW))
                   + ((2*tfn_pkg::MW)'(mhl_ff[c]) << (tfn_pkg::MHW + 1))
                   + (2*tfn_pkg::MW)'(mll_ff[c]);
      end
   end

   always_comb begin
      unit_in.degenerate = degen8_ff;
      unit_in.neg        = neg8_ff;
      unit_in.s_red      = tfn_pkg::SRW'(msq_ff[0]) + tfn_pkg::SRW'(msq_ff[1])
                         + tfn_pkg::SRW'(msq_ff[2]);
      for (int c = 0; c < 3; c++) unit_in.msq[c] = msq_ff[c];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         hh_ff   <= hh_in;
         hl_ff   <= hl_in;
         ll_ff   <= ll_in;
         mx_ff   <= mx_in;
         neg4_ff <= cross_i.neg;
         for (int c = 0; c < 3; c++) a4_ff[c] <= cross_i.mag[c];
      end
      if (en[1]) begin
         sq_ff   <= sq_in;
         sh_ff   <= sh_in;
         a5_ff   <= a4_ff;
         neg5_ff <= neg4_ff;
      end
      if (en[2]) begin
         s_ff    <= s_in;
         m6_ff   <= m6_in;
         neg6_ff <= neg5_ff;
      end
      if (en[3]) begin
         above_ff <= above_in;
         mhh_ff   <= mhh_in;
         mhl_ff   <= mhl_in;
         mll_ff   <= mll_in;
         neg7_ff  <= neg6_ff;
      end
      if (en[4]) begin
         msq_ff    <= msq_in;
         degen8_ff <= !above_ff;
         neg8_ff   <= neg7_ff;
      end
      if (en[5]) begin
         unit_ff <= unit_in;
      end
   end

   assign unit_o = unit_ff;

endmodule

### hw/rtl/tfn_norm.sv
// Digit-recurrence normalization, one quotient bit per stage, plus output register.
module tfn_norm (
   input  logic                           clock,
   input  logic [tfn_pkg::NSTEP+1:0]      en,
   input  tfn_pkg::unit_type              unit_i,
   output logic signed [tfn_pkg::OW-1:0]  normal_x,
   output logic signed [tfn_pkg::OW-1:0]  normal_y,
   output logic signed [tfn_pkg::OW-1:0]  normal_z,
   output logic                           degenerate
);

   // residual r = T - (x-1)^2 S', running p = (x-1) S', x = 2q
   logic signed [tfn_pkg::RW-1:0]  r_ff [tfn_pkg::NSTEP+1][3];
   logic signed [tfn_pkg::PPW-1:0] p_ff [tfn_pkg::NSTEP+1][3];
   logic [tfn_pkg::QW-1:0]         q_ff [tfn_pkg::NSTEP+1][3];
   logic [tfn_pkg::SRW-1:0]        s_ff [tfn_pkg::NSTEP+1];
   logic [2:0]                     neg_ff [tfn_pkg::NSTEP+1];
   logic                           degen_ff [tfn_pkg::NSTEP+1];
   logic signed [tfn_pkg::OW-1:0]  out_ff [3], out_in [3];
   logic                           degen_out_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int c = 0; c < 3; c++) begin
            r_ff[0][c] <= (tfn_pkg::RW'(unit_i.msq[c]) << tfn_pkg::QSH) - tfn_pkg::RW'(unit_i.s_red);
            p_ff[0][c] <= tfn_pkg::PPW'(0) - tfn_pkg::PPW'(unit_i.s_red);
            q_ff[0][c] <= '0;
         end
         s_ff[0]     <= unit_i.s_red;
         neg_ff[0]   <= unit_i.neg;
         degen_ff[0] <= unit_i.degenerate;
      end
   end

   for (genvar j = 1; j <= tfn_pkg::NSTEP; j++) begin : g_step
      localparam int K = tfn_pkg::NSTEP - j;
      logic signed [tfn_pkg::RW-1:0]  try_w [3];
      logic signed [tfn_pkg::RW-1:0]  r_in [3];
      logic signed [tfn_pkg::PPW-1:0] p_in [3];
      logic [tfn_pkg::QW-1:0]         q_in [3];

      always_comb begin
         for (int c = 0; c < 3; c++) begin
            try_w[c] = r_ff[j-1][c]
                     - (tfn_pkg::RW'(p_ff[j-1][c]) << (K + 2))
                     - (tfn_pkg::RW'(s_ff[j-1]) << (2 * K + 2));
            if (!try_w[c][tfn_pkg::RW-1]) begin
               r_in[c] = try_w[c];
               p_in[c] = p_ff[j-1][c] + (tfn_pkg::PPW'(s_ff[j-1]) << (K + 1));
               q_in[c] = q_ff[j-1][c] | (tfn_pkg::QW'(1) << K);
            end else begin
               r_in[c] = r_ff[j-1][c];
               p_in[c] = p_ff[j-1][c];
               q_in[c] = q_ff[j-1][c];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[j]) begin
            for (int c = 0; c < 3; c++) begin
               r_ff[j][c] <= r_in[c];
               p_ff[j][c] <= p_in[c];
               q_ff[j][c] <= q_in[c];
            end
            s_ff[j]     <= s_ff[j-1];
            neg_ff[j]   <= neg_ff[j-1];
            degen_ff[j] <= degen_ff[j-1];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (degen_ff[tfn_pkg::NSTEP])
            out_in[c] = '0;
         else if (neg_ff[tfn_pkg::NSTEP][c])
            out_in[c] = tfn_pkg::OW'(0) - tfn_pkg::OW'(q_ff[tfn_pkg::NSTEP][c]);
         else
            out_in[c] = tfn_pkg::OW'(q_ff[tfn_pkg::NSTEP][c]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[tfn_pkg::NSTEP+1]) begin
         out_ff       <= out_in;
         degen_out_ff <= degen_ff[tfn_pkg::NSTEP];
      end
   end

   assign normal_x   = out_ff[0];
   assign normal_y   = out_ff[1];
   assign normal_z   = out_ff[2];
   assign degenerate = degen_out_ff;

endmodule

### hw/rtl/triangle_face_normal_top.sv
// Top level of the triangle face normal pipeline: handshake, threshold register, stages.
//
// Takes one triangle (three vertices, signed 24-bit, 16 fractional bits) per item and
// returns its unit face normal as three Q1.14 components rounded to nearest, or a zero
// vector with degenerate set when the cross product length is not above min_length
// (units 2^-32). A new item can enter every clock unless a stalled output has backed
// up every stage. There are 26 register stages: three for edges and cross product,
// six for the squared length, threshold test and range reduction, one to set up and
// fifteen for the normalization (one quotient bit per stage per component), and one
// output register. Every stage holds its own valid bit and loads whenever it is empty
// or its successor moves, so bubbles collapse and a stalled output only backs up the
// stages behind it. Items accepted after a write to min_length use the new value;
// items still ahead of the threshold test at the write may use it too.

module triangle_face_normal_top (
   input  logic                           clock,
   input  logic                           reset,
   // input items
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [tfn_pkg::CW-1:0]  req_vertex_a_x,
   input  logic signed [tfn_pkg::CW-1:0]  req_vertex_a_y,
   input  logic signed [tfn_pkg::CW-1:0]  req_vertex_a_z,
   input  logic signed [tfn_pkg::CW-1:0]  req_vertex_b_x,
   input  logic signed [tfn_pkg::CW-1:0]  req_vertex_b_y,
   input  logic signed [tfn_pkg::CW-1:0]  req_vertex_b_z,
   input  logic signed [tfn_pkg::CW-1:0]  req_vertex_c_x,
   input  logic signed [tfn_pkg::CW-1:0]  req_vertex_c_y,
   input  logic signed [tfn_pkg::CW-1:0]  req_vertex_c_z,
   // result items
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [tfn_pkg::OW-1:0]  rsp_normal_x,
   output logic signed [tfn_pkg::OW-1:0]  rsp_normal_y,
   output logic signed [tfn_pkg::OW-1:0]  rsp_normal_z,
   output logic                           rsp_degenerate,
   // min_length register
   input  logic                           csr_wr_en,
   input  logic [tfn_pkg::LW-1:0]         csr_wr_data
);

   localparam int NCROSS = 3;
   localparam int NLEN   = 6;
   localparam int NNORM  = tfn_pkg::NSTEP + 2;
   localparam int NST    = NCROSS + NLEN + NNORM;

   logic [NST-1:0]          v_ff, v_in;
   logic [NST-1:0]          load;
   logic [tfn_pkg::LW-1:0]  min_ff;
   logic [tfn_pkg::TW-1:0]  thr_ff;
   tfn_pkg::cross_type      cross_w;
   tfn_pkg::unit_type       unit_w;

   // load chain: a stage takes new data when empty or when its item moves on
   always_comb begin
      load[NST-1] = !v_ff[NST-1] || !rsp_stall;
      for (int i = NST - 2; i >= 0; i--) begin
         load[i] = !v_ff[i] || load[i+1];
      end
      v_in[0] = load[0] ? req_valid : v_ff[0];
      for (int i = 1; i < NST; i++) begin
         v_in[i] = load[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         min_ff <= tfn_pkg::MIN_LENGTH_RESET;
      end else begin
         v_ff <= v_in;
         if (csr_wr_en) min_ff <= csr_wr_data;
      end
   end

   // squared threshold, compared against the exact squared length
   always_ff @(posedge clock) begin
      thr_ff <= min_ff * min_ff;
   end

   tfn_cross u_cross (
      .clock      (clock),
      .en         (load[NCROSS-1:0]),
      .vertex_a_x (req_vertex_a_x),
      .vertex_a_y (req_vertex_a_y),
      .vertex_a_z (req_vertex_a_z),
      .vertex_b_x (req_vertex_b_x),
      .vertex_b_y (req_vertex_b_y),
      .vertex_b_z (req_vertex_b_z),
      .vertex_c_x (req_vertex_c_x),
      .vertex_c_y (req_vertex_c_y),
      .vertex_c_z (req_vertex_c_z),
      .cross_o    (cross_w)
   );

   tfn_length u_length (
      .clock   (clock),
      .en      (load[NCROSS+NLEN-1:NCROSS]),
      .cross_i (cross_w),
      .thr     (thr_ff),
      .unit_o  (unit_w)
   );

   tfn_norm u_norm (
      .clock      (clock),
      .en         (load[NST-1:NCROSS+NLEN]),
      .unit_i     (unit_w),
      .normal_x   (rsp_normal_x),
      .normal_y   (rsp_normal_y),
      .normal_z   (rsp_normal_z),
      .degenerate (rsp_degenerate)
   );

   assign req_stall = !load[0];
   assign rsp_valid = v_ff[NST-1];

endmodule

### verif/triangle_face_normal_checker.sv
// Checker for the triangle face normal block: watches both channels, predicts and compares.
`timescale 1ns / 100ps

module triangle_face_normal_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [8:0][tfn_pkg::CW-1:0]   req_coords,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic signed [tfn_pkg::OW-1:0] rsp_normal_x,
   input  logic signed [tfn_pkg::OW-1:0] rsp_normal_y,
   input  logic signed [tfn_pkg::OW-1:0] rsp_normal_z,
   input  logic                          rsp_degenerate,
   input  logic                          csr_wr_en,
   input  logic [tfn_pkg::LW-1:0]        csr_wr_data,
   output int                            failures,
   output int                            normals_pending
);

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      logic               degenerate;
   } face_normal_type;

   face_normal_type          normal_queue[$];
   logic [tfn_pkg::LW-1:0]   min_length;

   // largest q in 0..16384 with (2q-1)^2 * sum <= 2^30 * m^2
   function automatic logic [15:0] unit_magnitude(input logic [127:0] m,
                                                  input logic [127:0] sum);
      logic [127:0] target;
      logic [127:0] t;
      int           lo;
      int           hi;
      int           mid;
      target = (m * m) << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         t = 128'(2 * mid - 1);
         if (sum * (t * t) <= target) lo = mid;
         else hi = mid - 1;
      end
      return 16'(lo);
   endfunction

   function automatic face_normal_type face_normal(input logic [8:0][tfn_pkg::CW-1:0] c,
                                                   input logic [31:0] thr);
      longint          v[9];
      longint          e1[3];
      longint          e2[3];
      longint          n[3];
      logic [127:0]    a[3];
      logic [127:0]    m[3];
      logic [127:0]    sum;
      logic [127:0]    thr_sq;
      logic [127:0]    mx;
      logic [15:0]     q;
      int              bits;
      int              sh;
      face_normal_type r;
      for (int i = 0; i < 9; i++) v[i] = longint'($signed(c[i]));
      for (int i = 0; i < 3; i++) begin
         e1[i] = v[3+i] - v[i];
         e2[i] = v[6+i] - v[i];
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      for (int i = 0; i < 3; i++) a[i] = 128'(n[i] < 0 ? -n[i] : n[i]);
      sum = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
      thr_sq = 128'(thr) * 128'(thr);
      r = '0;
      if (sum <= thr_sq) begin
         r.degenerate = 1'b1;
         return r;
      end
      mx = a[0];
      if (a[1] > mx) mx = a[1];
      if (a[2] > mx) mx = a[2];
      bits = 0;
      while (bits < 64 && (mx >> bits) != 0) bits++;
      sh = bits > 40 ? bits - 40 : 0;
      for (int i = 0; i < 3; i++) m[i] = a[i] >> sh;
      sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
      for (int i = 0; i < 3; i++) begin
         q = unit_magnitude(m[i], sum);
         if (n[i] < 0) q = -q;
         case (i)
            0: r.nx = q;
            1: r.ny = q;
            default: r.nz = q;
         endcase
      end
      return r;
   endfunction

   assign normals_pending = normal_queue.size();

   always @(posedge clock) begin
      face_normal_type want;
      if (reset) begin
         min_length <= tfn_pkg::MIN_LENGTH_RESET;
         failures   <= 0;
      end else begin
         if (req_valid && !req_stall)
            normal_queue = {normal_queue, face_normal(req_coords, min_length)};
         if (csr_wr_en) min_length <= csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            if (normal_queue.size() == 0) begin
               $error("result item with nothing expected");
               failures <= failures + 1;
            end else begin
               want = normal_queue.pop_front();
               if (rsp_normal_x !== want.nx || rsp_normal_y !== want.ny ||
                   rsp_normal_z !== want.nz || rsp_degenerate !== want.degenerate)
                  failures <= failures + 1;
               if (rsp_normal_x !== want.nx)
                  $error("normal_x expected %0d got %0d", want.nx, rsp_normal_x);
               if (rsp_normal_y !== want.ny)
                  $error("normal_y expected %0d got %0d", want.ny, rsp_normal_y);
               if (rsp_normal_z !== want.nz)
                  $error("normal_z expected %0d got %0d", want.nz, rsp_normal_z);
               if (rsp_degenerate !== want.degenerate)
                  $error("degenerate expected %0d got %0d", want.degenerate, rsp_degenerate);
            end
         end
      end
   end

endmodule

### verif/testbench.sv
// Top of the triangle face normal testbench: clock, reset, stimulus, threshold writes, verdict.
`timescale 1ns / 100ps

module testbench;

   localparam int LATENCY  = 26;
   localparam int WATCHDOG = 5000;   // cycles without any item moving
   localparam int RANDOM_PER_PHASE = 350;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [8:0][tfn_pkg::CW-1:0]   req_coords = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [tfn_pkg::OW-1:0] rsp_normal_x;
   logic signed [tfn_pkg::OW-1:0] rsp_normal_y;
   logic signed [tfn_pkg::OW-1:0] rsp_normal_z;
   logic                          rsp_degenerate;
   logic                          csr_wr_en = 1'b0;
   logic [tfn_pkg::LW-1:0]        csr_wr_data = '0;
   int                            failures;
   int                            normals_pending;
   int                            send_idle_pct = 0;
   int                            stall_pct = 0;
   int                            quiet_cycles = 0;

   always #2 clock = ~clock;

   triangle_face_normal_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_vertex_a_x (req_coords[0]),
      .req_vertex_a_y (req_coords[1]),
      .req_vertex_a_z (req_coords[2]),
      .req_vertex_b_x (req_coords[3]),
      .req_vertex_b_y (req_coords[4]),
      .req_vertex_b_z (req_coords[5]),
      .req_vertex_c_x (req_coords[6]),
      .req_vertex_c_y (req_coords[7]),
      .req_vertex_c_z (req_coords[8]),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_normal_x   (rsp_normal_x),
      .rsp_normal_y   (rsp_normal_y),
      .rsp_normal_z   (rsp_normal_z),
      .rsp_degenerate (rsp_degenerate),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   triangle_face_normal_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_coords      (req_coords),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_normal_x    (rsp_normal_x),
      .rsp_normal_y    (rsp_normal_y),
      .rsp_normal_z    (rsp_normal_z),
      .rsp_degenerate  (rsp_degenerate),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .failures        (failures),
      .normals_pending (normals_pending)
   );

   // receiver back-pressure, changed on the falling edge only
   always @(negedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   // watchdog: any cycle with no item moving on either channel counts
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // present one triangle and hold it until it is taken; valid stays high between
   // back-to-back items, gaps only come from the idle percentage
   task automatic send_triangle(input logic [8:0][tfn_pkg::CW-1:0] tri_coords);
      bit taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_coords = tri_coords;
      req_valid  = 1'b1;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
      end
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // wait for the pipe to drain, then a write of min_length
   task automatic set_min_length(input logic [31:0] value);
      req_valid = 1'b0;
      while (normals_pending != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [23:0] any_coord();
      return 24'($urandom);
   endfunction

   // small signed value in -span..span
   function automatic logic [23:0] near_zero(input int span);
      return 24'($urandom_range(2 * span) - span);
   endfunction

   task automatic send_random_triangle();
      logic [8:0][tfn_pkg::CW-1:0] c;
      int kind;
      int k;
      int span;
      kind = $urandom_range(99);
      if (kind < 35) begin
         // full range of every coordinate
         for (int i = 0; i < 9; i++) c[i] = any_coord();
      end else if (kind < 70) begin
         // small triangle somewhere: lengths close to the threshold
         span = 1 << $urandom_range(12);
         for (int i = 0; i < 3; i++) c[i] = any_coord() >>> 1;
         for (int i = 3; i < 9; i++) c[i] = c[i % 3] + near_zero(span);
      end else if (kind < 85) begin
         // collinear vertices: always zero area
         k = $urandom_range(6) - 3;
         for (int i = 0; i < 6; i++) c[i] = near_zero(1 << 20);
         for (int i = 0; i < 3; i++)
            c[6+i] = 24'($signed(c[i]) + k * ($signed(c[3+i]) - $signed(c[i])));
      end else begin
         // coordinates at the edges of the range
         for (int i = 0; i < 9; i++)
            case ($urandom_range(3))
               0: c[i] = 24'h800000;
               1: c[i] = 24'h7FFFFF;
               2: c[i] = 24'h000000;
               default: c[i] = 24'hFFFFFF;
            endcase
      end
      send_triangle(c);
   endtask

   task automatic send_directed();
      // zero triangle, all vertices equal
      send_triangle('0);
      send_triangle({9{24'h7FFFFF}});
      // unit right triangles along each plane: normals are exactly one axis
      send_triangle({24'h0, 24'h010000, 24'h0, 24'h0, 24'h0, 24'h010000, 24'h0, 24'h0, 24'h0});
      send_triangle({24'h010000, 24'h0, 24'h0, 24'h0, 24'h010000, 24'h0, 24'h0, 24'h0, 24'h0});
      send_triangle({24'h0, 24'h0, 24'h010000, 24'h010000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h0});
      // reversed winding: negative components
      send_triangle({24'h0, 24'h0, 24'h010000, 24'h0, 24'h010000, 24'h0, 24'h0, 24'h0, 24'h0});
      // extremes: largest edges in every direction
      send_triangle({24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000,
                     24'h7FFFFF, 24'h7FFFFF, 24'h800000});
      send_triangle({24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                     24'h800000, 24'h800000, 24'h7FFFFF});
      send_triangle({24'h800000, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000,
                     24'h7FFFFF, 24'h800000, 24'h800000});
      // one-LSB triangle: tiniest nonzero cross product
      send_triangle({24'h0, 24'h000001, 24'h0, 24'h0, 24'h0, 24'h000001, 24'h0, 24'h0, 24'h0});
      // cross product of 65 * 66 = 4290 units, just below the reset threshold, then
      // exactly at it and one unit above
      send_triangle({24'h0, 24'd65, 24'h0, 24'h0, 24'h0, 24'd66, 24'h0, 24'h0, 24'h0});
      send_triangle({24'h0, 24'd1, 24'h0, 24'h0, 24'h0, 24'd4295, 24'h0, 24'h0, 24'h0});
      send_triangle({24'h0, 24'd1, 24'h0, 24'h0, 24'h0, 24'd4296, 24'h0, 24'h0, 24'h0});
      // collinear at full range
      send_triangle({24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h0, 24'h0, 24'h0,
                     24'h800001, 24'h800001, 24'h800001});
      // equal magnitudes (1/sqrt(3) in each component), then a triangle with unequal ones
      send_triangle({24'h0, 24'h010000, 24'h0, 24'h010000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h010000});
      send_triangle({24'h0, 24'h0FFFF0, 24'h0, 24'h003000, 24'h0, 24'h0, 24'h0, 24'h0, 24'h000123});
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // threshold at its reset value, no idling
      send_directed();
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_triangle();

      // threshold zero, sender idle most cycles
      set_min_length(32'h0);
      send_idle_pct = 63;
      send_directed();
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_triangle();

      // threshold at its top, receiver stalling most cycles
      set_min_length(32'hFFFFFFFF);
      send_idle_pct = 0;
      stall_pct = 63;
      send_directed();
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_triangle();

      // random threshold, both sides idling now and then
      set_min_length($urandom >> $urandom_range(31));
      send_idle_pct = 19;
      stall_pct = 19;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_triangle();

      // back to the reset value, no idling
      set_min_length(tfn_pkg::MIN_LENGTH_RESET);
      send_idle_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < RANDOM_PER_PHASE; i++) send_random_triangle();

      while (normals_pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (failures == 0 && normals_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
